/* rtl/core/lzwbe_pkg.sv */
// Shared types and constants of the LZW byte encoder.
// No dependencies; every other file of the block refers to this package by scoped names.
package lzwbe_pkg;

	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 12;
	localparam int WIDTH_W     = 5;
	localparam int WM1_W       = 4;
	localparam int NEXT_W      = 13;

	localparam int DICT_SIZE_DEF   = 4096;
	localparam int START_BITS_DEF  = 8;
	localparam int START_LIMIT_DEF = 511;

	localparam logic [NEXT_W-1:0] FIRST_CODE = NEXT_W'(256);
	localparam logic [NEXT_W-1:0] LIMIT_MAX  = NEXT_W'(8191);
	localparam logic [WM1_W-1:0]  WM1_MAX    = WM1_W'(15);

	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_KEY,
		ST_SECOND
	} eng_state_t;

	typedef struct packed {
		logic              last;
		logic [WIDTH_W-1:0] width;
		logic [CODE_W-1:0]  code;
	} out_item_t;

endpackage

/* rtl/core/lzwbe_dict.sv */
// Dictionary storage: the child map, indexed by (prefix, byte), and the key store,
// indexed by code, which proves that a child map entry belongs to the current dictionary.
// Depends on lzwbe_pkg.
module lzwbe_dict #(
	parameter int DICT_SIZE = lzwbe_pkg::DICT_SIZE_DEF
) (
	input  logic                                        clk,
	input  logic                                        map_rd_en,
	input  logic [$clog2(DICT_SIZE)+lzwbe_pkg::BYTE_W-1:0] map_rd_addr,
	output logic [lzwbe_pkg::CODE_W-1:0]                map_rd_data,
	input  logic                                        key_rd_en,
	input  logic [$clog2(DICT_SIZE)-1:0]                key_rd_addr,
	output logic [$clog2(DICT_SIZE)+lzwbe_pkg::BYTE_W-1:0] key_rd_data,
	input  logic                                        wr_en,
	input  logic [$clog2(DICT_SIZE)+lzwbe_pkg::BYTE_W-1:0] wr_idx,
	input  logic [$clog2(DICT_SIZE)-1:0]                wr_code
);

	localparam int PFX_W     = $clog2(DICT_SIZE);
	localparam int IDX_W     = PFX_W + lzwbe_pkg::BYTE_W;
	localparam int MAP_DEPTH = DICT_SIZE * 256;

	logic [lzwbe_pkg::CODE_W-1:0] child_map [MAP_DEPTH];
	logic [IDX_W-1:0]             key_mem   [DICT_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			child_map[wr_idx] <= lzwbe_pkg::CODE_W'(wr_code);
		end
		if (map_rd_en) begin
			map_rd_data <= child_map[map_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_code] <= wr_idx;
		end
		if (key_rd_en) begin
			key_rd_data <= key_mem[key_rd_addr];
		end
	end

endmodule

/* rtl/core/lzwbe_out_fifo.sv */
// Two-beat result queue between the encoder engine and the output stream.
// Depends on lzwbe_pkg.
module lzwbe_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lzwbe_pkg::out_item_t  push_item,
	output logic                  push_ready,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output lzwbe_pkg::out_item_t  pop_item
);

	lzwbe_pkg::out_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/lzwbe_engine.sv */
// Encoder sequencer: holds the prefix, code counter, width and growth limit, and runs
// the read, verify and write-back steps on the dictionary memories.
// Depends on lzwbe_pkg; drives lzwbe_dict and feeds lzwbe_out_fifo.
module lzwbe_engine #(
	parameter int DICT_SIZE   = lzwbe_pkg::DICT_SIZE_DEF,
	parameter int START_BITS  = lzwbe_pkg::START_BITS_DEF,
	parameter int START_LIMIT = lzwbe_pkg::START_LIMIT_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	input  logic                                        in_cmd,
	input  logic [lzwbe_pkg::BYTE_W-1:0]                in_byte,
	output logic                                        in_take,
	output logic                                        map_rd_en,
	output logic [$clog2(DICT_SIZE)+lzwbe_pkg::BYTE_W-1:0] map_rd_addr,
	input  logic [lzwbe_pkg::CODE_W-1:0]                map_rd_data,
	output logic                                        key_rd_en,
	output logic [$clog2(DICT_SIZE)-1:0]                key_rd_addr,
	input  logic [$clog2(DICT_SIZE)+lzwbe_pkg::BYTE_W-1:0] key_rd_data,
	output logic                                        wr_en,
	output logic [$clog2(DICT_SIZE)+lzwbe_pkg::BYTE_W-1:0] wr_idx,
	output logic [$clog2(DICT_SIZE)-1:0]                wr_code,
	output logic                                        push,
	output lzwbe_pkg::out_item_t                        push_item,
	input  logic                                        push_ready
);

	localparam int PFX_W = $clog2(DICT_SIZE);
	localparam int IDX_W = PFX_W + lzwbe_pkg::BYTE_W;
	localparam logic [lzwbe_pkg::NEXT_W-1:0] DICT_END   = lzwbe_pkg::NEXT_W'(DICT_SIZE);
	localparam logic [lzwbe_pkg::WM1_W-1:0]  WM1_RESET  = lzwbe_pkg::WM1_W'(START_BITS);
	localparam logic [lzwbe_pkg::NEXT_W-1:0] LIMIT_RESET = lzwbe_pkg::NEXT_W'(START_LIMIT);

	lzwbe_pkg::eng_state_t state_q, state_d;

	logic [lzwbe_pkg::CODE_W-1:0]  prefix_q, prefix_d;
	logic                          held_q, held_d;
	logic [lzwbe_pkg::NEXT_W-1:0]  next_code_q, next_code_d;
	logic [lzwbe_pkg::WM1_W-1:0]   wm1_q, wm1_d;
	logic [lzwbe_pkg::NEXT_W-1:0]  limit_q, limit_d;
	logic [lzwbe_pkg::BYTE_W-1:0]  byte_q, byte_d;
	logic                          range_ok_q, range_ok_d;

	logic [IDX_W-1:0]              cur_idx;
	logic                          grow;
	logic [lzwbe_pkg::WM1_W-1:0]   wm1_inc;
	logic [lzwbe_pkg::NEXT_W-1:0]  limit_dbl;
	logic                          hit;

	function automatic logic [lzwbe_pkg::WIDTH_W-1:0] send_width(
		input logic [lzwbe_pkg::WM1_W-1:0] wm1
	);
		return lzwbe_pkg::WIDTH_W'({1'b0, wm1}) + lzwbe_pkg::WIDTH_W'(1);
	endfunction

	assign cur_idx   = {prefix_q[PFX_W-1:0], byte_q};
	assign grow      = (next_code_q > limit_q);
	assign wm1_inc   = (wm1_q < lzwbe_pkg::WM1_MAX) ? wm1_q + lzwbe_pkg::WM1_W'(1) : wm1_q;
	assign limit_dbl = limit_q[lzwbe_pkg::NEXT_W-1] ? lzwbe_pkg::LIMIT_MAX
		: {limit_q[lzwbe_pkg::NEXT_W-2:0], 1'b0};

	// An entry counts only if its code was handed out in this dictionary and the key
	// store confirms that this very (prefix, byte) pair received it. Stale entries from
	// earlier dictionaries, or never written ones, fail one of the two tests.
	always_comb begin
		hit = 1'b0;
		if (range_ok_q && (key_rd_data == cur_idx)) begin
			hit = 1'b1;
		end
	end

	assign map_rd_addr = {prefix_q[PFX_W-1:0], in_byte};
	assign key_rd_addr = map_rd_data[PFX_W-1:0];
	assign wr_idx      = cur_idx;
	assign wr_code     = next_code_q[PFX_W-1:0];

	always_comb begin
		state_d     = state_q;
		prefix_d    = prefix_q;
		held_d      = held_q;
		next_code_d = next_code_q;
		wm1_d       = wm1_q;
		limit_d     = limit_q;
		byte_d      = byte_q;
		range_ok_d  = range_ok_q;
		in_take     = 1'b0;
		map_rd_en   = 1'b0;
		key_rd_en   = 1'b0;
		wr_en       = 1'b0;
		push        = 1'b0;
		push_item   = '{last: 1'b1, width: send_width(wm1_q), code: prefix_q};

		unique case (state_q)
			lzwbe_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd) begin
						// End of stream: send any held prefix, then start a fresh stream.
						if (!held_q || push_ready) begin
							in_take = 1'b1;
							if (held_q) begin
								push = 1'b1;
								push_item.width = send_width(grow ? wm1_inc : wm1_q);
							end
							prefix_d    = '0;
							held_d      = 1'b0;
							next_code_d = lzwbe_pkg::FIRST_CODE;
							wm1_d       = WM1_RESET;
							limit_d     = LIMIT_RESET;
						end
					end else if (!held_q) begin
						in_take  = 1'b1;
						prefix_d = lzwbe_pkg::CODE_W'(in_byte);
						held_d   = 1'b1;
					end else begin
						in_take   = 1'b1;
						map_rd_en = 1'b1;
						byte_d    = in_byte;
						state_d   = lzwbe_pkg::ST_MAP;
					end
				end
			end
			lzwbe_pkg::ST_MAP: begin
				key_rd_en  = 1'b1;
				range_ok_d = 1'b0;
				if ((map_rd_data >= lzwbe_pkg::FIRST_CODE[lzwbe_pkg::CODE_W-1:0])
					&& ({1'b0, map_rd_data} < next_code_q)) begin
					range_ok_d = 1'b1;
				end
				state_d = lzwbe_pkg::ST_KEY;
			end
			lzwbe_pkg::ST_KEY: begin
				if (hit) begin
					prefix_d = map_rd_data;
					state_d  = lzwbe_pkg::ST_IDLE;
				end else if (push_ready) begin
					push = 1'b1;
					if (next_code_q < DICT_END) begin
						if (grow) begin
							wm1_d           = wm1_inc;
							limit_d         = limit_dbl;
							push_item.width = send_width(wm1_inc);
						end
						wr_en       = 1'b1;
						next_code_d = next_code_q + lzwbe_pkg::NEXT_W'(1);
						prefix_d    = lzwbe_pkg::CODE_W'(byte_q);
						state_d     = lzwbe_pkg::ST_IDLE;
					end else begin
						push_item.last = 1'b0;
						state_d        = lzwbe_pkg::ST_SECOND;
					end
				end
			end
			lzwbe_pkg::ST_SECOND: begin
				// Dictionary full: the byte goes out on its own code, then the dictionary
				// restarts; moving next_code back retires every stored entry at once.
				if (push_ready) begin
					push           = 1'b1;
					push_item.code = lzwbe_pkg::CODE_W'(byte_q);
					prefix_d       = '0;
					held_d         = 1'b0;
					next_code_d    = lzwbe_pkg::FIRST_CODE;
					wm1_d          = WM1_RESET;
					limit_d        = LIMIT_RESET;
					state_d        = lzwbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzwbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzwbe_pkg::ST_IDLE;
			prefix_q    <= '0;
			held_q      <= 1'b0;
			next_code_q <= lzwbe_pkg::FIRST_CODE;
			wm1_q       <= WM1_RESET;
			limit_q     <= LIMIT_RESET;
		end else begin
			state_q     <= state_d;
			prefix_q    <= prefix_d;
			held_q      <= held_d;
			next_code_q <= next_code_d;
			wm1_q       <= wm1_d;
			limit_q     <= limit_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q     <= byte_d;
		range_ok_q <= range_ok_d;
	end

endmodule

/* rtl/core/lzw_byte_encoder.sv */
// LZW byte encoder top level: input beat register, sequencer, dictionary memories
// and result queue. Depends on lzwbe_pkg, lzwbe_dict, lzwbe_engine and lzwbe_out_fifo.
//
// Usage: each slave beat carries one byte in s_tdata, with s_tuser set to mark the end
// of a stream instead. Each master beat carries one code and the number of its low bits
// to send, MSB first; m_tlast marks the final result caused by an input beat. Bit packing
// is done downstream.
// Steps: a byte that extends a held prefix runs through a child map read, a key store
// read to confirm the entry, then decide and write back; the first byte of a stream and
// an end of stream are handled in the idle step alone; a byte that finds the dictionary
// full needs a further step after those and produces two results. A result is registered
// in the result queue before it appears on the master side. A one-beat input register
// lets the next beat in while the current one is being worked on.
// Reset clears the prefix, code counter, width and limit; the dictionary needs no clearing
// pass, since an entry is trusted only when its code lies below the code counter and the
// key store confirms it. When the receiver stalls, the two-beat result queue fills, the
// sequencer waits before emitting, and the input register then holds s_tready low.
module lzw_byte_encoder #(
	parameter int DICT_SIZE   = lzwbe_pkg::DICT_SIZE_DEF,
	parameter int START_BITS  = lzwbe_pkg::START_BITS_DEF,
	parameter int START_LIMIT = lzwbe_pkg::START_LIMIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lzwbe_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] byte_value
	input  logic [0:0]                         s_tuser,   // [0] cmd (end of stream)
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lzwbe_pkg::OUT_DATA_W-1:0]   m_tdata,   // [11:0] out_code, [16:12] out_width
	output logic                               m_tlast
);

	localparam int PFX_W = $clog2(DICT_SIZE);
	localparam int IDX_W = PFX_W + lzwbe_pkg::BYTE_W;

	logic                         in_full_q;
	logic                         in_cmd_q;
	logic [lzwbe_pkg::BYTE_W-1:0] in_byte_q;
	logic                         in_take;

	logic                         map_rd_en;
	logic [IDX_W-1:0]             map_rd_addr;
	logic [lzwbe_pkg::CODE_W-1:0] map_rd_data;
	logic                         key_rd_en;
	logic [PFX_W-1:0]             key_rd_addr;
	logic [IDX_W-1:0]             key_rd_data;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_idx;
	logic [PFX_W-1:0]             wr_code;

	logic                         push;
	lzwbe_pkg::out_item_t         push_item;
	logic                         push_ready;
	lzwbe_pkg::out_item_t         pop_item;

	assign s_tready = !in_full_q || in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_full_q <= 1'b1;
		end else if (in_take) begin
			in_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_cmd_q  <= s_tuser[0];
			in_byte_q <= s_tdata;
		end
	end

	lzwbe_engine #(
		.DICT_SIZE   (DICT_SIZE),
		.START_BITS  (START_BITS),
		.START_LIMIT (START_LIMIT)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_full_q),
		.in_cmd      (in_cmd_q),
		.in_byte     (in_byte_q),
		.in_take     (in_take),
		.map_rd_en   (map_rd_en),
		.map_rd_addr (map_rd_addr),
		.map_rd_data (map_rd_data),
		.key_rd_en   (key_rd_en),
		.key_rd_addr (key_rd_addr),
		.key_rd_data (key_rd_data),
		.wr_en       (wr_en),
		.wr_idx      (wr_idx),
		.wr_code     (wr_code),
		.push        (push),
		.push_item   (push_item),
		.push_ready  (push_ready)
	);

	lzwbe_dict #(
		.DICT_SIZE (DICT_SIZE)
	) u_dict (
		.clk         (clk),
		.map_rd_en   (map_rd_en),
		.map_rd_addr (map_rd_addr),
		.map_rd_data (map_rd_data),
		.key_rd_en   (key_rd_en),
		.key_rd_addr (key_rd_addr),
		.key_rd_data (key_rd_data),
		.wr_en       (wr_en),
		.wr_idx      (wr_idx),
		.wr_code     (wr_code)
	);

	lzwbe_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (m_tvalid),
		.pop_ready  (m_tready),
		.pop_item   (pop_item)
	);

	assign m_tdata = {
		(lzwbe_pkg::OUT_DATA_W - lzwbe_pkg::CODE_W - lzwbe_pkg::WIDTH_W)'(0),
		pop_item.width,
		pop_item.code
	};
	assign m_tlast = pop_item.last;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for lzw_byte_encoder: directed byte streams and dictionary growth,
// then random streams; every emitted code is predicted here and checked per beat.
// Depends on lzwbe_pkg and the encoder RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_value
	logic [0:0]  s_tuser = 1'b0;    // [0] cmd (end of stream)
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;           // [11:0] out_code, [16:12] out_width
	logic        m_tlast;

	// Bench copy of the encoder state.
	logic [11:0] child_code [logic [19:0]];
	logic [11:0] held_code;
	bit          have_prefix;
	logic [12:0] free_code;
	logic [4:0]  width_m1;
	logic [12:0] grow_limit;

	lzwbe_pkg::out_item_t codes_due [$];

	bit          idle_on = 1'b1;
	int unsigned fails = 0;
	int unsigned beats_in = 0;
	int unsigned codes_out = 0;
	int unsigned full_events = 0;
	int unsigned flush_codes = 0;
	int unsigned widest = 0;
	int unsigned cycles = 0;
	int unsigned rx_hold = 0;

	lzw_byte_encoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d codes still due", cycles, codes_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: while idle_on is set, ready drops at random; rx_hold sets how long each drop lasts.
	always @(posedge clk) begin
		if (!m_tready && rx_hold == 0) begin
			m_tready <= 1'b1;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_hold <= $urandom_range(0, 2);
		end
	end

	function automatic void clear_dict();
		child_code.delete();
		free_code = lzwbe_pkg::FIRST_CODE;
		width_m1 = 5'(lzwbe_pkg::START_BITS_DEF);
		grow_limit = 13'(lzwbe_pkg::START_LIMIT_DEF);
	endfunction

	function automatic void restart_stream();
		clear_dict();
		held_code = 12'd0;
		have_prefix = 1'b0;
	endfunction

	function automatic void widen();
		if (width_m1 < 5'(lzwbe_pkg::WM1_MAX))
			width_m1 = width_m1 + 5'd1;
	endfunction

	function automatic void emit_code(input logic [11:0] code, input logic last);
		lzwbe_pkg::out_item_t r;
		r.code = code;
		r.width = 5'(width_m1 + 5'd1);
		r.last = last;
		codes_due.push_back(r);
	endfunction

	// Advances the bench state by one accepted beat and queues the codes it causes.
	function automatic void encode_beat(input logic flush, input logic [7:0] b);
		logic [19:0] key;
		logic [13:0] doubled;
		if (flush) begin
			if (have_prefix) begin
				if (free_code > grow_limit)
					widen();
				emit_code(held_code, 1'b1);
				flush_codes++;
			end
			restart_stream();
			return;
		end
		if (!have_prefix) begin
			held_code = {4'd0, b};
			have_prefix = 1'b1;
			return;
		end
		key = {held_code, b};
		if (child_code.exists(key)) begin
			held_code = child_code[key];
			return;
		end
		if (free_code < 13'(lzwbe_pkg::DICT_SIZE_DEF)) begin
			if (free_code > grow_limit) begin
				doubled = {grow_limit, 1'b0};
				grow_limit = (doubled > 14'(lzwbe_pkg::LIMIT_MAX)) ?
					lzwbe_pkg::LIMIT_MAX : doubled[12:0];
				widen();
			end
			emit_code(held_code, 1'b1);
			child_code[key] = free_code[11:0];
			free_code = free_code + 13'd1;
			held_code = {4'd0, b};
			return;
		end
		// Dictionary full: the prefix, then the byte itself, then a fresh start.
		emit_code(held_code, 1'b0);
		emit_code({4'd0, b}, 1'b1);
		clear_dict();
		held_code = 12'd0;
		have_prefix = 1'b0;
		full_events++;
	endfunction

	// Valid stays high after a beat so back-to-back beats need no second assignment.
	task automatic send_beat(input logic flush, input logic [7:0] b);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= flush;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		encode_beat(flush, b);
		beats_in++;
	endtask

	always @(posedge clk) begin
		lzwbe_pkg::out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			codes_out++;
			if (codes_due.size() == 0) begin
				$error("unexpected beat: code %0d width %0d last %0b",
					m_tdata[11:0], m_tdata[16:12], m_tlast);
				fails++;
			end else begin
				want = codes_due.pop_front();
				if (m_tdata[11:0] !== want.code) begin
					$error("out_code: expected %0d, got %0d", want.code, m_tdata[11:0]);
					fails++;
				end
				if (m_tdata[16:12] !== want.width) begin
					$error("out_width: expected %0d, got %0d", want.width, m_tdata[16:12]);
					fails++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
					fails++;
				end
				if (m_tdata[23:17] !== 7'd0) begin
					$error("tdata padding: expected 0, got %0h", m_tdata[23:17]);
					fails++;
				end
				if (want.width > widest)
					widest = want.width;
			end
		end
	end

	// End of stream with and without a held prefix, including a prefix of code zero.
	task automatic test_flush_cases();
		send_beat(1'b1, 8'h00);
		send_beat(1'b1, 8'hFF);
		send_beat(1'b0, 8'h00);
		send_beat(1'b1, 8'h5A);
		send_beat(1'b0, 8'hFF);
		send_beat(1'b1, 8'h00);
	endtask

	task automatic test_hits_and_extremes();
		logic [7:0] seq [15] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h80, 8'h7F, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01};
		foreach (seq[i])
			send_beat(1'b0, seq[i]);
		send_beat(1'b1, 8'hA5);
	endtask

	// Stop exactly when the next code passes the limit, so the final prefix goes out wider.
	task automatic test_width_step_at_flush();
		while (!(have_prefix && free_code > grow_limit))
			send_beat(1'b0, 8'($urandom));
		send_beat(1'b1, 8'($urandom));
	endtask

	task automatic test_random_streams(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		logic [7:0] base;
		bit narrow;
		sent = 0;
		while (sent < n_items) begin
			run_len = $urandom_range(1, 48);
			narrow = ($urandom_range(0, 9) < 7);
			base = 8'($urandom);
			// A narrow alphabet keeps the dictionary hitting and prefixes growing long.
			for (int unsigned k = 0; k < run_len; k++) begin
				if (narrow)
					send_beat(1'b0, base ^ 8'($urandom_range(0, 3)));
				else
					send_beat(1'b0, 8'($urandom));
			end
			sent += run_len;
			if ($urandom_range(0, 9) != 0) begin
				send_beat(1'b1, 8'($urandom));
				sent++;
			end
			if ($urandom_range(0, 19) == 0) begin
				send_beat(1'b1, 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		restart_stream();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flush_cases();
		test_hits_and_extremes();
		test_width_step_at_flush();
		test_random_streams(950);
		idle_on = 1'b0;
		test_random_streams(100);
		send_beat(1'b1, 8'h00);

		s_tvalid <= 1'b0;
		while (codes_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d beats and checked %0d codes, widest code %0d bits.",
			beats_in, codes_out, widest);
		$display("Streams closed with a code: %0d, dictionary overflows: %0d.",
			flush_codes, full_events);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/lzwbe_pkg.sv
rtl/core/lzwbe_dict.sv
rtl/core/lzwbe_out_fifo.sv
rtl/core/lzwbe_engine.sv
rtl/core/lzw_byte_encoder.sv
bench/tb_top.sv
